/* hdl/b58_pkg.sv */
// Shared types, constants and alphabet lookup for the base-58 encoder.
`timescale 1ns / 1ps

package b58_pkg;

  // Field widths of the item and result ports
  localparam int BYTE_W  = 8;
  localparam int DIGIT_W = 6;
  localparam int SYM_W   = 7;
  localparam int LEN_W   = 7;

  // Message size and digit store sizing (digits = bytes * log(256)/log(58), rounded up)
  localparam int MAX_BYTES_DEF = 32;
  localparam int DIG_NUM       = 138;
  localparam int DIG_DEN       = 100;

  // Division by 58 as a reciprocal multiply: floor(x * 1130 / 2^16) is exact for x < 2^14
  localparam int BASE       = 58;
  localparam int RECIP_MUL  = 1130;
  localparam int RECIP_SH   = 16;
  localparam int RECIP_W    = 11;

  // Depth of the command queue between front and back
  localparam int CMD_DEPTH = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAP   = 1'b1;
  localparam logic [LEN_W-1:0]     CAP_RESET     = 7'd65;

  // Alphabets, first character in the top byte
  localparam int ALPHA_LEN = 58;
  localparam logic [ALPHA_LEN*8-1:0] STD_ALPHA =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
  localparam logic [ALPHA_LEN*8-1:0] ALT_ALPHA =
    "rpshnaf39wBUDNEGHJKLM4PQRST7VWXYZ2bcdeCg65jkm8oFqi1tuvAxyz";

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;
    logic             too_small;
    logic [LEN_W-1:0] required_len;
  } res_t;

  // Work handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              fold;     // fold this byte into the digit store
    logic              finish;   // message ends after this command
    logic [LEN_W-1:0]  lzc;      // leading zero bytes of the message so far
  } cmd_t;

  // ASCII code of digit d in the selected alphabet
  function automatic logic [SYM_W-1:0] alpha_char(input logic sel,
                                                  input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] idx;
    logic [7:0]         c;
    idx = DIGIT_W'(ALPHA_LEN - 1) - d;
    if (d > DIGIT_W'(ALPHA_LEN - 1)) begin
      c = 8'd0;
    end else if (sel) begin
      c = ALT_ALPHA[{idx, 3'b000} +: 8];
    end else begin
      c = STD_ALPHA[{idx, 3'b000} +: 8];
    end
    return c[SYM_W-1:0];
  endfunction

endpackage

/* hdl/base58_encoder.sv */
// Top level of the base-58 encoder: configuration registers and block wiring.
`timescale 1ns / 1ps

// Bytes of a message go in on start_i while busy_o is low, most significant
// first, with last_byte on the final one. Leading zero bytes and bytes past
// MAX_BYTES stay in the front and are not folded. Every other byte is folded
// into the digit store by one multiply-add-divide-by-58 step that handles one
// digit per cycle; the length of a fold is set by how many digits are already
// significant. A two-entry command queue lets the front take further bytes
// while a fold runs; busy_o rises when it is full. After the last byte the
// engine checks the length, then gives its results one per cycle: one
// leading '1'-class character per zero byte, then (after a memory read) the
// significant digits; the store is then cleared. Results appear on res_o for
// one cycle with res_strobe_o high and cannot be held off, so the receiver
// must take them as they come. On a capacity shortfall a single result with
// too_small set is given. The user must write configuration through
// cfg_we_i/cfg_idx_i/cfg_data_i while idle; the block does not enforce it.
module base58_encoder #(
  parameter int MAX_BYTES = b58_pkg::MAX_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  b58_pkg::in_t                  in_i,
  output logic                          busy_o,
  output b58_pkg::res_t                 res_o,
  output logic                          res_strobe_o,
  input  logic                          cfg_we_i,
  input  logic [b58_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [b58_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic                       alpha_sel_q;
  logic [b58_pkg::LEN_W-1:0]  capacity_q;

  logic                       fifo_full;
  logic                       fifo_empty;
  logic                       fifo_push;
  logic                       fifo_pop;
  b58_pkg::cmd_t              push_cmd;
  b58_pkg::cmd_t              pop_cmd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_sel_q <= 1'b0;
      capacity_q  <= b58_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        b58_pkg::CFG_ALPHA_SEL: alpha_sel_q <= cfg_data_i[0];
        b58_pkg::CFG_OUT_CAP:   capacity_q  <= cfg_data_i[b58_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  b58_front #(
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .in_i    (in_i),
    .busy_o  (busy_o),
    .full_i  (fifo_full),
    .push_o  (fifo_push),
    .cmd_o   (push_cmd)
  );

  b58_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (push_cmd),
    .full_o      (fifo_full),
    .pop_i       (fifo_pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (fifo_empty)
  );

  b58_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (pop_cmd),
    .empty_i      (fifo_empty),
    .pop_o        (fifo_pop),
    .alpha_sel_i  (alpha_sel_q),
    .capacity_i   (capacity_q),
    .res_o        (res_o),
    .res_strobe_o (res_strobe_o)
  );

endmodule

/* hdl/b58_front.sv */
// Front end: takes message bytes, counts leading zeros and issues commands.
`timescale 1ns / 1ps

module b58_front #(
  parameter int MAX_BYTES = b58_pkg::MAX_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  b58_pkg::in_t    in_i,
  output logic            busy_o,
  input  logic            full_i,
  output logic            push_o,
  output b58_pkg::cmd_t   cmd_o
);

  localparam int CW = $clog2(MAX_BYTES + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] lzc_q, lzc_d;
  logic          seen_q, seen_d;

  logic          accept;
  logic          counted;
  logic          is_lz;
  logic          do_fold;
  logic [CW-1:0] lzc_inc;

  assign busy_o  = full_i;
  assign accept  = start_i && !full_i;

  // Classify the byte: ignored past the limit, leading zero, or folded
  assign counted = cnt_q < CW'(MAX_BYTES);
  assign is_lz   = counted && !seen_q && (in_i.data_byte == '0);
  assign do_fold = counted && !is_lz;
  assign lzc_inc = lzc_q + CW'(is_lz);

  // Only folds and message ends need the back end
  assign push_o          = accept && (do_fold || in_i.last_byte);
  assign cmd_o.data_byte = in_i.data_byte;
  assign cmd_o.fold      = do_fold;
  assign cmd_o.finish    = in_i.last_byte;
  assign cmd_o.lzc       = b58_pkg::LEN_W'(lzc_inc);

  // Per-message counters, cleared by the last byte
  always_comb begin
    cnt_d  = cnt_q;
    lzc_d  = lzc_q;
    seen_d = seen_q;
    if (accept) begin
      if (in_i.last_byte) begin
        cnt_d  = '0;
        lzc_d  = '0;
        seen_d = 1'b0;
      end else if (counted) begin
        cnt_d = cnt_q + CW'(1);
        lzc_d = lzc_inc;
        if (!is_lz) begin
          seen_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      lzc_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      lzc_q  <= lzc_d;
      seen_q <= seen_d;
    end
  end

endmodule

/* hdl/b58_cmd_fifo.sv */
// Short command queue between the front end and the digit engine.
`timescale 1ns / 1ps

module b58_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  b58_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output b58_pkg::cmd_t pop_data_o,
  output logic          empty_o
);

  localparam int DEPTH = b58_pkg::CMD_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  b58_pkg::cmd_t entry_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] fill_q;
  logic          do_push, do_pop;

  assign full_o     = fill_q == NW'(DEPTH);
  assign empty_o    = fill_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + NW'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - NW'(1);
      end
    end
  end

endmodule

/* hdl/b58_back.sv */
// Digit engine: folds bytes into the base-58 store and emits the characters.
`timescale 1ns / 1ps

module b58_back #(
  parameter int MAX_BYTES = b58_pkg::MAX_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  b58_pkg::cmd_t              cmd_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  input  logic                       alpha_sel_i,
  input  logic [b58_pkg::LEN_W-1:0]  capacity_i,
  output b58_pkg::res_t              res_o,
  output logic                       res_strobe_o
);

  localparam int DIGITS = MAX_BYTES * b58_pkg::DIG_NUM / b58_pkg::DIG_DEN + 1;
  localparam int IW     = $clog2(DIGITS);
  localparam int FW     = $clog2(DIGITS + 1);
  localparam int DW     = b58_pkg::DIGIT_W;
  localparam int BW     = b58_pkg::BYTE_W;
  localparam int LW     = b58_pkg::LEN_W;
  localparam int XW     = DW + BW;
  localparam int PRW    = XW + b58_pkg::RECIP_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SWEEP  = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_ZERO   = 3'd3;
  localparam logic [2:0] ST_DPRIME = 3'd4;
  localparam logic [2:0] ST_DIGIT  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]          state_q, state_d;
  b58_pkg::cmd_t       cmd_q, cmd_d;
  logic [IW-1:0]       j_q, j_d;
  logic [BW-1:0]       carry_q, carry_d;
  logic [IW-1:0]       top_q, top_d;
  logic [FW-1:0]       fnz_q, fnz_d;
  logic [LW-1:0]       zc_q, zc_d;
  logic [IW-1:0]       k_q, k_d;
  logic [LW-1:0]       req_q, req_d;
  b58_pkg::res_t       res_q, res_d;
  logic                strobe_q, strobe_d;

  // Digit store with one valid flag per entry
  logic [DW-1:0]       mem [DIGITS];
  logic [DIGITS-1:0]   valid_q;
  logic [DW-1:0]       rdata_q;
  logic                rvalid_q;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [DW-1:0]       mem_wdata;
  logic [IW-1:0]       mem_raddr;
  logic                clr_valid;

  logic [DW-1:0]       cur_digit;
  logic [XW-1:0]       x;
  logic [PRW-1:0]      prod;
  logic [BW-1:0]       quo;
  logic [XW-1:0]       quo_x58;
  logic [XW-1:0]       rem;
  logic                go;
  logic [FW-1:0]       sig;
  logic [LW:0]         required;

  // One multiply-add-divmod step: x = digit * 256 + carry
  assign cur_digit = rvalid_q ? rdata_q : '0;
  assign x         = {cur_digit, carry_q};
  assign prod      = PRW'(x) * PRW'(b58_pkg::RECIP_MUL);
  assign quo       = prod[b58_pkg::RECIP_SH +: BW];
  assign quo_x58   = XW'(quo) * XW'(b58_pkg::BASE);
  assign rem       = x - quo_x58;
  assign go        = (j_q > top_q) || (carry_q != '0);

  // Length of the encoding, terminator slot included
  assign sig      = FW'(DIGITS) - fnz_q;
  assign required = {1'b0, cmd_q.lzc} + (LW + 1)'(sig) + (LW + 1)'(1);

  assign res_o        = res_q;
  assign res_strobe_o = strobe_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    j_d       = j_q;
    carry_d   = carry_q;
    top_d     = top_q;
    fnz_d     = fnz_q;
    zc_d      = zc_q;
    k_d       = k_q;
    req_d     = req_q;
    res_d     = res_q;
    strobe_d  = 1'b0;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = j_q;
    mem_wdata = rem[DW-1:0];
    mem_raddr = '0;
    clr_valid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          if (cmd_i.fold) begin
            j_d       = IW'(DIGITS - 1);
            carry_d   = cmd_i.data_byte;
            mem_raddr = IW'(DIGITS - 1);
            state_d   = ST_SWEEP;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_SWEEP: begin
        if (!go) begin
          top_d   = j_q;
          state_d = cmd_q.finish ? ST_CHECK : ST_IDLE;
        end else begin
          mem_we = 1'b1;
          if ((rem[DW-1:0] != '0) && (FW'(j_q) < fnz_q)) begin
            fnz_d = FW'(j_q);
          end
          if (j_q == '0) begin
            top_d   = '0;
            state_d = cmd_q.finish ? ST_CHECK : ST_IDLE;
          end else begin
            j_d       = j_q - IW'(1);
            carry_d   = quo;
            mem_raddr = j_q - IW'(1);
          end
        end
      end
      ST_CHECK: begin
        req_d = required[LW-1:0];
        zc_d  = cmd_q.lzc;
        if ({1'b0, capacity_i} < required) begin
          strobe_d           = 1'b1;
          res_d.symbol       = '0;
          res_d.last_symbol  = 1'b1;
          res_d.too_small    = 1'b1;
          res_d.required_len = required[LW-1:0];
          state_d            = ST_DONE;
        end else if (cmd_q.lzc != '0) begin
          state_d = ST_ZERO;
        end else begin
          state_d = ST_DPRIME;
        end
      end
      ST_ZERO: begin
        strobe_d           = 1'b1;
        res_d.symbol       = b58_pkg::alpha_char(alpha_sel_i, '0);
        res_d.last_symbol  = (zc_q == LW'(1)) && (sig == '0);
        res_d.too_small    = 1'b0;
        res_d.required_len = req_q;
        zc_d               = zc_q - LW'(1);
        if (zc_q == LW'(1)) begin
          state_d = (sig == '0) ? ST_DONE : ST_DPRIME;
        end
      end
      ST_DPRIME: begin
        k_d       = fnz_q[IW-1:0];
        mem_raddr = fnz_q[IW-1:0];
        state_d   = ST_DIGIT;
      end
      ST_DIGIT: begin
        strobe_d           = 1'b1;
        res_d.symbol       = b58_pkg::alpha_char(alpha_sel_i, cur_digit);
        res_d.last_symbol  = k_q == IW'(DIGITS - 1);
        res_d.too_small    = 1'b0;
        res_d.required_len = req_q;
        if (k_q == IW'(DIGITS - 1)) begin
          state_d = ST_DONE;
        end else begin
          k_d       = k_q + IW'(1);
          mem_raddr = k_q + IW'(1);
        end
      end
      ST_DONE: begin
        // Message state back to empty
        clr_valid = 1'b1;
        top_d     = IW'(DIGITS - 1);
        fnz_d     = FW'(DIGITS);
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Digit store ports, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q  <= mem[mem_raddr];
    rvalid_q <= valid_q[mem_raddr];
  end

  // Valid flags: set on write, all dropped at message end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_valid) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[mem_waddr] <= 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      top_q    <= IW'(DIGITS - 1);
      fnz_q    <= FW'(DIGITS);
      zc_q     <= '0;
      k_q      <= '0;
      j_q      <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      fnz_q    <= fnz_d;
      zc_q     <= zc_d;
      k_q      <= k_d;
      j_q      <= j_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    carry_q <= carry_d;
    req_q   <= req_d;
    res_q   <= res_d;
  end

endmodule
